// File: sv/serial_command_line_framer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial command line framer
// Every check samples on aclk and is switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_FRAMER_CORE_MACROS_SVH
`define SERIAL_COMMAND_LINE_FRAMER_CORE_MACROS_SVH

// Antecedent holds in a cycle, so the consequent holds in the same cycle
`define SCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, so the consequent holds in the next cycle
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Types, codes and sizes shared by the serial command line framer.
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int LINE_DEPTH    = 128;
    localparam int HOST_READ_LEN = 32;
    // only the host-readable part of the line needs storing
    localparam int RD_DEPTH = (HOST_READ_LEN < LINE_DEPTH) ? HOST_READ_LEN : LINE_DEPTH;
    localparam int PTR_W    = $clog2(LINE_DEPTH);
    localparam int RD_AW    = (RD_DEPTH > 1) ? $clog2(RD_DEPTH) : 1;

    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 5;
    localparam int SETCH_LEN = 6;
    localparam int CH_POS    = 6;
    localparam int HEAD_LEN  = 7;

    localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] SET_CH_WORD [SETCH_LEN] =
        '{8'h53, 8'h45, 8'h54, 8'h5F, 8'h43, 8'h48};

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        EV_STORED  = 3'd0,
        EV_BUSY    = 3'd1,
        EV_TEST    = 3'd2,
        EV_SETCH   = 3'd3,
        EV_HELD    = 3'd4,
        EV_READ_OK = 3'd5,
        EV_READ_NO = 3'd6,
        EV_CLEARED = 3'd7
    } event_t;

    typedef struct packed {
        logic              wr_en;
        logic [RD_AW-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [RD_AW-1:0]  rd_addr;
    } mem_req_t;

    typedef struct packed {
        event_t            event_code;
        logic [BYTE_W-1:0] value;
    } result_t;

endpackage

// File: sv/serial_command_line_framer_core.sv
// ----------------------------------------------------------------------------
// serial_command_line_framer_core
// Frames received serial bytes into command lines and answers host reads.
// ----------------------------------------------------------------------------
// Takes one beat per cycle on s_ (received byte, host read or host clear)
// while s_ready is high, and gives one result beat on m_ for each, in order;
// request type 3 gives none. A result is registered in the framing stage,
// together with the buffer read, then in the output register. The output
// side has a skid register, so a stalled m_ready costs input throughput only
// once both result slots are full. The line head (entries 0..6) sits in
// flops for the command compare; entries 0..31 go to a one-write/one-read
// buffer whose read is registered, with per-entry valid bits so the buffer
// reads as zero after reset without a clearing pass.
// ----------------------------------------------------------------------------
module serial_command_line_framer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [scl_pkg::BYTE_W-1:0]    s_rx_byte,
    input  logic [scl_pkg::IDX_W-1:0]     s_read_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_event_code,
    output logic [scl_pkg::BYTE_W-1:0]    m_value
);

    scl_pkg::mem_req_t          mem_req;
    logic [scl_pkg::BYTE_W-1:0] rd_data;
    logic                       res_valid;
    logic                       res_ready;
    scl_pkg::result_t           res;

    scl_framer u_framer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_rx_byte    (s_rx_byte),
        .s_read_index (s_read_index),
        .mem_req      (mem_req),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready)
    );

    scl_line_mem u_line_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    scl_out_buf u_out_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (res_valid),
        .in_ready     (res_ready),
        .in_res       (res),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_value      (m_value)
    );

endmodule

// File: sv/scl_line_mem.sv
// ----------------------------------------------------------------------------
// scl_line_mem
// Host-readable head of the line buffer: one write and one registered read
// a cycle. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module scl_line_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scl_pkg::mem_req_t             mem_req,
    output logic [scl_pkg::BYTE_W-1:0]    rd_data
);

    logic [scl_pkg::BYTE_W-1:0]   mem [scl_pkg::RD_DEPTH];
    logic [scl_pkg::RD_DEPTH-1:0] valid_reg;
    logic [scl_pkg::BYTE_W-1:0]   rd_data_reg;
    logic                         rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg  <= mem[mem_req.rd_addr];
            rd_valid_reg <= valid_reg[mem_req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_req.wr_en) begin
            valid_reg[mem_req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: sv/scl_framer.sv
// ----------------------------------------------------------------------------
// scl_framer
// Per-beat framing logic: write pointer, held-line flag, line head copy,
// terminator and prefix detection, and the stage register for the result.
// ----------------------------------------------------------------------------
`include "serial_command_line_framer_core_macros.svh"

module scl_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [scl_pkg::BYTE_W-1:0]    s_rx_byte,
    input  logic [scl_pkg::IDX_W-1:0]     s_read_index,
    output scl_pkg::mem_req_t             mem_req,
    input  logic [scl_pkg::BYTE_W-1:0]    rd_data,
    output logic                          res_valid,
    output scl_pkg::result_t              res,
    input  logic                          res_ready
);

    logic [scl_pkg::PTR_W-1:0]  wp_reg, wp_next, wp_inc;
    logic                       line_ready_reg, line_ready_next;
    logic [scl_pkg::BYTE_W-1:0] head_reg  [scl_pkg::HEAD_LEN];
    logic [scl_pkg::BYTE_W-1:0] head_next [scl_pkg::HEAD_LEN];
    logic [scl_pkg::BYTE_W-1:0] head_eff  [scl_pkg::HEAD_LEN];
    logic [scl_pkg::BYTE_W-1:0] prev_reg, prev_next;

    logic                       s1_valid_reg;
    scl_pkg::event_t            s1_code_reg, s1_code_next;
    logic [scl_pkg::BYTE_W-1:0] s1_value_reg, s1_value_next;
    logic                       s1_use_rd_reg, s1_use_rd_next;

    logic                       accept;
    logic                       emit;
    logic                       term;
    logic                       is_test;
    logic                       is_setch;
    scl_pkg::req_t              req;

    assign req     = scl_pkg::req_t'(s_req_type);
    assign s_ready = !s1_valid_reg || res_ready;
    assign accept  = s_valid && s_ready;

    assign wp_inc = (wp_reg == scl_pkg::PTR_W'(scl_pkg::LINE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // line head as it stands once this beat's byte is in
    always_comb begin
        for (int k = 0; k < scl_pkg::HEAD_LEN; k++) begin
            head_eff[k] = (wp_reg == scl_pkg::PTR_W'(k)) ? s_rx_byte : head_reg[k];
        end
    end

    always_comb begin
        is_setch = 1'b1;
        for (int k = 0; k < scl_pkg::SETCH_LEN; k++) begin
            if (head_eff[k] != scl_pkg::SET_CH_WORD[k]) begin
                is_setch = 1'b0;
            end
        end
    end

    assign is_test = (head_eff[0] == scl_pkg::CHR_QUERY);
    // pointer not at 0 means the previous byte belongs to this line
    assign term = (wp_reg != '0) && (prev_reg == scl_pkg::CHR_LF)
                  && (s_rx_byte == scl_pkg::CHR_CR);

    always_comb begin
        wp_next         = wp_reg;
        line_ready_next = line_ready_reg;
        head_next       = head_reg;
        prev_next       = prev_reg;
        emit            = 1'b0;
        s1_code_next    = scl_pkg::EV_STORED;
        s1_value_next   = '0;
        s1_use_rd_next  = 1'b0;
        mem_req         = '0;
        mem_req.wr_addr = wp_reg[scl_pkg::RD_AW-1:0];
        mem_req.wr_data = s_rx_byte;
        mem_req.rd_addr = s_read_index[scl_pkg::RD_AW-1:0];

        if (accept) begin
            case (req)
                scl_pkg::REQ_BYTE: begin
                    emit = 1'b1;
                    if (line_ready_reg) begin
                        s1_code_next = scl_pkg::EV_BUSY;
                    end else begin
                        prev_next     = s_rx_byte;
                        head_next     = head_eff;
                        mem_req.wr_en = (int'(wp_reg) < scl_pkg::RD_DEPTH);
                        wp_next       = wp_inc;
                        if (term) begin
                            wp_next = '0;
                            if (is_test) begin
                                s1_code_next = scl_pkg::EV_TEST;
                            end else if (is_setch) begin
                                s1_code_next  = scl_pkg::EV_SETCH;
                                s1_value_next = head_eff[scl_pkg::CH_POS];
                            end else begin
                                s1_code_next    = scl_pkg::EV_HELD;
                                line_ready_next = 1'b1;
                            end
                        end
                    end
                end
                scl_pkg::REQ_READ: begin
                    emit = 1'b1;
                    if (line_ready_reg && (int'(s_read_index) < scl_pkg::RD_DEPTH)) begin
                        s1_code_next   = scl_pkg::EV_READ_OK;
                        s1_use_rd_next = 1'b1;
                        mem_req.rd_en  = 1'b1;
                    end else begin
                        s1_code_next = scl_pkg::EV_READ_NO;
                    end
                end
                scl_pkg::REQ_CLEAR: begin
                    emit            = 1'b1;
                    line_ready_next = 1'b0;
                    wp_next         = '0;
                    s1_code_next    = scl_pkg::EV_CLEARED;
                end
                default: begin
                    // unused request type: no result, nothing changes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            line_ready_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            for (int k = 0; k < scl_pkg::HEAD_LEN; k++) begin
                head_reg[k] <= '0;
            end
        end else begin
            wp_reg         <= wp_next;
            line_ready_reg <= line_ready_next;
            head_reg       <= head_next;
            if (s_ready) begin
                s1_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        if (s_ready && emit) begin
            s1_code_reg   <= s1_code_next;
            s1_value_reg  <= s1_value_next;
            s1_use_rd_reg <= s1_use_rd_next;
        end
    end

    assign res_valid      = s1_valid_reg;
    assign res.event_code = s1_code_reg;
    assign res.value      = s1_use_rd_reg ? rd_data : s1_value_reg;

    `SCL_ASSERT_SAME(a_held_no_store, line_ready_reg, !mem_req.wr_en, "byte stored while line held")
    `SCL_ASSERT_SAME(a_read_needs_line, mem_req.rd_en, line_ready_reg, "buffer read with no line held")
    `SCL_ASSERT_NEXT(a_clear_resets, accept && (req == scl_pkg::REQ_CLEAR), !line_ready_reg && (wp_reg == '0), "clear left state behind")
    `SCL_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !res_ready, s1_valid_reg && $stable(s1_code_reg) && $stable(res.value), "stalled stage changed")

endmodule

// File: sv/scl_out_buf.sv
// ----------------------------------------------------------------------------
// scl_out_buf
// Two-entry result buffer: output register plus skid register, so the
// upstream ready is taken from a flop and not from m_ready.
// ----------------------------------------------------------------------------
`include "serial_command_line_framer_core_macros.svh"

module scl_out_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  scl_pkg::result_t              in_res,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_event_code,
    output logic [scl_pkg::BYTE_W-1:0]    m_value
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    scl_pkg::result_t out_reg;
    scl_pkg::result_t skid_reg;
    logic             push;
    logic             pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : in_res;
        end else if (push) begin
            skid_reg <= in_res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_code = out_reg.event_code;
    assign m_value      = out_reg.value;

    `SCL_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `SCL_ASSERT_NEXT(a_stall_to_skid, push && out_valid_reg && !m_ready, skid_valid_reg, "stalled beat not parked")
    `SCL_ASSERT_NEXT(a_skid_drains_first, skid_valid_reg && m_ready, out_reg == $past(skid_reg), "skid beat overtaken")

endmodule
